FILE: hw/rtl/task_runtime_profiler_macros.svh
// assertion macros for the task run-time profiler
`ifndef TASK_RUNTIME_PROFILER_MACROS_SVH
`define TASK_RUNTIME_PROFILER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define TRP_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("trp assertion failed");
// next-cycle implication
`define TRP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("trp assertion failed");
`else
`define TRP_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define TRP_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

FILE: hw/rtl/trp_pkg.sv
// shared types and constants for the task run-time profiler
package trp_pkg;

    localparam int unsigned SLOTS_DEFAULT = 32;
    localparam int unsigned TASK_W        = 16;
    localparam int unsigned TIME_W        = 34;
    localparam int unsigned STAMP_W       = 32;
    localparam int unsigned RSLOT_W       = 5;
    localparam int unsigned STATUS_W      = 3;
    localparam int unsigned COUNT_W       = 6;
    localparam int unsigned CFG_IDX_W     = 1;
    localparam int unsigned CFG_DATA_W    = 32;

    localparam logic [STAMP_W-1:0] THR_RESET = 32'd5000;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_CHARGED    = 3'd0,
        ST_FULL       = 3'd1,
        ST_DISABLED   = 3'd2,
        ST_READ_VALID = 3'd3,
        ST_READ_EMPTY = 3'd4
    } status_t;

    typedef struct packed {
        logic [TASK_W-1:0] task_id;
        logic [TIME_W-1:0] time_us;
    } slot_entry_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_CLR,
        IDX_INC,
        IDX_DEC,
        IDX_ALLOC
    } idx_op_t;

    typedef enum logic [1:0] {
        RA_IDX,
        RA_IDX_M1,
        RA_WALK,
        RA_READ
    } raddr_sel_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_CHARGE,
        WR_HALF,
        WR_SWAP_LO,
        WR_SWAP_HI
    } wr_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RD_ADDR,
        S_RD_LATCH,
        S_SEARCH,
        S_MATCH,
        S_CHARGE,
        S_DECAY,
        S_HALF_RD,
        S_HALF_WR,
        S_SWAP_RD,
        S_SWAP_LD,
        S_SWAP_CMP,
        S_SWAP_WR,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic       load_item;
        idx_op_t    idx_op;
        raddr_sel_t raddr_sel;
        wr_op_t     wr_op;
        logic       cur_load;
        logic       walk_clr;
        logic       walk_inc;
        logic       halve_total;
        logic       emit;
        status_t    emit_status;
    } dp_cmd_t;

    typedef struct packed {
        logic is_read;
        logic rd_hit;
        logic enabled;
        logic idx_at_end;
        logic table_full;
        logic match;
        logic over_thr;
        logic walk_at_end;
        logic idx_zero;
        logic cur_greater;
        logic out_free;
    } dp_status_t;

endpackage

FILE: hw/rtl/task_runtime_profiler.sv
// top level of the task run-time profiler
// Profiles run time per task id from switch items (command 0) and reports one table slot
// and the totals on read items (command 1); every item gives exactly one result. The table
// lives in a single RAM that the controller walks one slot at a time, so the cost of an
// item follows that port: an enabled switch compares the used slots in turn until one
// matches, allocates a new slot when none matches and the table is not full, halves the
// total and all used slots when the total passes the decay threshold, and swaps the
// charged slot with its neighbour when it now holds more time. While the previous result
// still waits in the output register, the next result cannot be loaded. One item is in
// work at a time; a new item is taken while the previous result still waits in the output
// register. The table needs no clearing after reset: only slots below the entry count are
// ever read.
`include "task_runtime_profiler_macros.svh"
module task_runtime_profiler #(
    parameter int unsigned SLOTS = trp_pkg::SLOTS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [trp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [trp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_command,
    input  logic [trp_pkg::STAMP_W-1:0]       s_timestamp_us,
    input  logic [trp_pkg::TASK_W-1:0]        s_incoming_task,
    input  logic [trp_pkg::RSLOT_W-1:0]       s_read_slot,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [trp_pkg::STATUS_W-1:0]      m_status,
    output logic [trp_pkg::RSLOT_W-1:0]       m_slot,
    output logic [trp_pkg::TASK_W-1:0]        m_entry_task,
    output logic [trp_pkg::TIME_W-1:0]        m_entry_time,
    output logic [trp_pkg::TIME_W-1:0]        m_total_time,
    output logic [trp_pkg::COUNT_W-1:0]       m_entry_count
);

    import trp_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_sts;

    trp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .in_ready (s_ready),
        .sts      (dp_sts),
        .cmd      (dp_cmd)
    );

    trp_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_command       (s_command),
        .s_timestamp_us  (s_timestamp_us),
        .s_incoming_task (s_incoming_task),
        .s_read_slot     (s_read_slot),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_slot          (m_slot),
        .m_entry_task    (m_entry_task),
        .m_entry_time    (m_entry_time),
        .m_total_time    (m_total_time),
        .m_entry_count   (m_entry_count),
        .cmd             (dp_cmd),
        .sts             (dp_sts)
    );

    // a slot never holds more than the total
    `TRP_ASSERT_IMPL(a_entry_le_total, aclk, aresetn, m_valid && (m_status == ST_CHARGED || m_status == ST_READ_VALID), m_entry_time <= m_total_time)
    // one item in work at a time
    `TRP_ASSERT_NEXT(a_one_item, aclk, aresetn, s_valid && s_ready, !s_ready)
    // a result is loaded only when the output register is free
    `TRP_ASSERT_IMPL(a_emit_free, aclk, aresetn, dp_cmd.emit, !m_valid || m_ready)

endmodule

FILE: hw/rtl/trp_ram.sv
// generic single-port-write ram with registered read
module trp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/trp_ctrl.sv
// controller state machine for the task run-time profiler
module trp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                in_ready,
    input  trp_pkg::dp_status_t sts,
    output trp_pkg::dp_cmd_t    cmd
);

    import trp_pkg::*;

    state_t  state_reg, state_next;
    logic    found_reg, found_next;
    status_t status_reg, status_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            found_reg  <= 1'b0;
            status_reg <= ST_CHARGED;
        end else begin
            state_reg  <= state_next;
            found_reg  <= found_next;
            status_reg <= status_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        found_next  = found_reg;
        status_next = status_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (sts.is_read) begin
                    if (sts.rd_hit) begin
                        state_next = S_RD_ADDR;
                    end else begin
                        status_next = ST_READ_EMPTY;
                        state_next  = S_EMIT;
                    end
                end else if (!sts.enabled) begin
                    status_next = ST_DISABLED;
                    state_next  = S_EMIT;
                end else begin
                    cmd.idx_op = IDX_CLR;
                    found_next = 1'b0;
                    state_next = S_SEARCH;
                end
            end
            S_RD_ADDR: begin
                cmd.raddr_sel = RA_READ;
                state_next    = S_RD_LATCH;
            end
            S_RD_LATCH: begin
                cmd.cur_load = 1'b1;
                status_next  = ST_READ_VALID;
                state_next   = S_EMIT;
            end
            S_SEARCH: begin
                if (sts.idx_at_end) begin
                    if (sts.table_full) begin
                        state_next = S_DECAY;
                    end else begin
                        cmd.idx_op = IDX_ALLOC;
                        found_next = 1'b1;
                        state_next = S_CHARGE;
                    end
                end else begin
                    cmd.raddr_sel = RA_IDX;
                    state_next    = S_MATCH;
                end
            end
            S_MATCH: begin
                if (sts.match) begin
                    cmd.cur_load = 1'b1;
                    found_next   = 1'b1;
                    state_next   = S_CHARGE;
                end else begin
                    cmd.idx_op = IDX_INC;
                    state_next = S_SEARCH;
                end
            end
            S_CHARGE: begin
                cmd.wr_op  = WR_CHARGE;
                state_next = S_DECAY;
            end
            S_DECAY: begin
                if (sts.over_thr) begin
                    cmd.halve_total = 1'b1;
                    cmd.walk_clr    = 1'b1;
                    state_next      = S_HALF_RD;
                end else if (found_reg) begin
                    state_next = S_SWAP_RD;
                end else begin
                    status_next = ST_FULL;
                    state_next  = S_EMIT;
                end
            end
            S_HALF_RD: begin
                if (sts.walk_at_end) begin
                    if (found_reg) begin
                        state_next = S_SWAP_RD;
                    end else begin
                        status_next = ST_FULL;
                        state_next  = S_EMIT;
                    end
                end else begin
                    cmd.raddr_sel = RA_WALK;
                    state_next    = S_HALF_WR;
                end
            end
            S_HALF_WR: begin
                cmd.wr_op    = WR_HALF;
                cmd.walk_inc = 1'b1;
                state_next   = S_HALF_RD;
            end
            S_SWAP_RD: begin
                cmd.raddr_sel = RA_IDX;
                state_next    = S_SWAP_LD;
            end
            S_SWAP_LD: begin
                cmd.cur_load  = 1'b1;
                cmd.raddr_sel = RA_IDX_M1;
                status_next   = ST_CHARGED;
                if (sts.idx_zero) begin
                    state_next = S_EMIT;
                end else begin
                    state_next = S_SWAP_CMP;
                end
            end
            S_SWAP_CMP: begin
                if (sts.cur_greater) begin
                    cmd.wr_op  = WR_SWAP_LO;
                    state_next = S_SWAP_WR;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_SWAP_WR: begin
                cmd.wr_op  = WR_SWAP_HI;
                cmd.idx_op = IDX_DEC;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = status_reg;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/trp_datapath.sv
// datapath for the task run-time profiler: slot table, totals and result register
module trp_datapath #(
    parameter int unsigned SLOTS = trp_pkg::SLOTS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [trp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [trp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_command,
    input  logic [trp_pkg::STAMP_W-1:0]       s_timestamp_us,
    input  logic [trp_pkg::TASK_W-1:0]        s_incoming_task,
    input  logic [trp_pkg::RSLOT_W-1:0]       s_read_slot,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [trp_pkg::STATUS_W-1:0]      m_status,
    output logic [trp_pkg::RSLOT_W-1:0]       m_slot,
    output logic [trp_pkg::TASK_W-1:0]        m_entry_task,
    output logic [trp_pkg::TIME_W-1:0]        m_entry_time,
    output logic [trp_pkg::TIME_W-1:0]        m_total_time,
    output logic [trp_pkg::COUNT_W-1:0]       m_entry_count,
    input  trp_pkg::dp_cmd_t                  cmd,
    output trp_pkg::dp_status_t               sts
);

    import trp_pkg::*;

    localparam int unsigned SLOT_W = $clog2(SLOTS);
    localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
    localparam int unsigned ENT_W  = $bits(slot_entry_t);

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [STAMP_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + (TIME_W + 1)'(b);
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

    // configuration
    logic                  enable_reg;
    logic [STAMP_W-1:0]    thr_reg;

    // item
    logic                  cmd_reg;
    logic [STAMP_W-1:0]    stamp_reg;
    logic [STAMP_W-1:0]    diff_reg;
    logic [TASK_W-1:0]     incoming_reg;
    logic [RSLOT_W-1:0]    rs_reg;

    // profiler state
    logic [CNT_W-1:0]      used_reg;
    logic [TIME_W-1:0]     total_reg;
    logic [TASK_W-1:0]     prev_task_reg;
    logic [STAMP_W-1:0]    prev_stamp_reg;

    // work registers
    logic [CNT_W-1:0]      idx_reg;
    logic [CNT_W-1:0]      walk_reg;
    slot_entry_t           cur_reg;

    // result
    logic                  m_valid_reg;
    status_t               status_reg;
    logic [RSLOT_W-1:0]    slot_reg;
    logic [TASK_W-1:0]     etask_reg;
    logic [TIME_W-1:0]     etime_reg;
    logic [TIME_W-1:0]     total_out_reg;
    logic [COUNT_W-1:0]    count_reg;

    // table
    logic                  ram_we;
    logic [SLOT_W-1:0]     ram_waddr;
    logic [SLOT_W-1:0]     ram_raddr;
    slot_entry_t           ram_wdata;
    slot_entry_t           ram_rdata;
    logic [ENT_W-1:0]      ram_rdata_raw;
    logic [TIME_W-1:0]     charged_time;

    trp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata    = slot_entry_t'(ram_rdata_raw);
    assign charged_time = sat_add(cur_reg.time_us, diff_reg);

    always_comb begin
        case (cmd.raddr_sel)
            RA_IDX:    ram_raddr = SLOT_W'(idx_reg);
            RA_IDX_M1: ram_raddr = SLOT_W'(idx_reg - CNT_W'(1));
            RA_WALK:   ram_raddr = SLOT_W'(walk_reg);
            RA_READ:   ram_raddr = SLOT_W'(rs_reg);
            default:   ram_raddr = SLOT_W'(idx_reg);
        endcase
    end

    always_comb begin
        ram_we    = 1'b1;
        ram_waddr = SLOT_W'(idx_reg);
        ram_wdata = cur_reg;
        case (cmd.wr_op)
            WR_NONE: begin
                ram_we = 1'b0;
            end
            WR_CHARGE: begin
                ram_wdata.task_id = prev_task_reg;
                ram_wdata.time_us = charged_time;
            end
            WR_HALF: begin
                ram_waddr         = SLOT_W'(walk_reg);
                ram_wdata.task_id = ram_rdata.task_id;
                ram_wdata.time_us = ram_rdata.time_us >> 1;
            end
            WR_SWAP_LO: begin
                ram_wdata = ram_rdata;
            end
            WR_SWAP_HI: begin
                ram_waddr = SLOT_W'(idx_reg - CNT_W'(1));
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b1;
            thr_reg    <= THR_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ENABLE: enable_reg <= cfg_wdata[0];
                CFG_DECAY:  thr_reg    <= cfg_wdata;
                default:    thr_reg    <= thr_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            cmd_reg      <= s_command;
            stamp_reg    <= s_timestamp_us;
            diff_reg     <= s_timestamp_us - prev_stamp_reg;
            incoming_reg <= s_incoming_task;
            rs_reg       <= s_read_slot;
        end
        if (cmd.cur_load) begin
            cur_reg <= ram_rdata;
        end else if (cmd.idx_op == IDX_ALLOC) begin
            cur_reg.task_id <= prev_task_reg;
            cur_reg.time_us <= '0;
        end else if (cmd.wr_op == WR_CHARGE) begin
            cur_reg.time_us <= charged_time;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg       <= '0;
            total_reg      <= '0;
            prev_task_reg  <= '0;
            prev_stamp_reg <= '0;
            idx_reg        <= '0;
            walk_reg       <= '0;
        end else begin
            case (cmd.idx_op)
                IDX_HOLD:  idx_reg <= idx_reg;
                IDX_CLR:   idx_reg <= '0;
                IDX_INC:   idx_reg <= idx_reg + CNT_W'(1);
                IDX_DEC:   idx_reg <= idx_reg - CNT_W'(1);
                IDX_ALLOC: begin
                    idx_reg  <= used_reg;
                    used_reg <= used_reg + CNT_W'(1);
                end
                default:   idx_reg <= idx_reg;
            endcase
            if (cmd.walk_clr) begin
                walk_reg <= '0;
            end else if (cmd.walk_inc) begin
                walk_reg <= walk_reg + CNT_W'(1);
            end
            if (cmd.wr_op == WR_CHARGE) begin
                total_reg <= sat_add(total_reg, diff_reg);
            end else if (cmd.halve_total) begin
                total_reg <= total_reg >> 1;
            end
            if (cmd.emit && (cmd.emit_status == ST_CHARGED || cmd.emit_status == ST_FULL)) begin
                prev_task_reg  <= incoming_reg;
                prev_stamp_reg <= stamp_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            status_reg    <= cmd.emit_status;
            total_out_reg <= total_reg;
            count_reg     <= COUNT_W'(used_reg);
            case (cmd.emit_status)
                ST_CHARGED: begin
                    slot_reg  <= RSLOT_W'(idx_reg);
                    etask_reg <= cur_reg.task_id;
                    etime_reg <= cur_reg.time_us;
                end
                ST_READ_VALID: begin
                    slot_reg  <= rs_reg;
                    etask_reg <= cur_reg.task_id;
                    etime_reg <= cur_reg.time_us;
                end
                ST_READ_EMPTY: begin
                    slot_reg  <= rs_reg;
                    etask_reg <= '0;
                    etime_reg <= '0;
                end
                default: begin
                    slot_reg  <= '0;
                    etask_reg <= '0;
                    etime_reg <= '0;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_slot        = slot_reg;
    assign m_entry_task  = etask_reg;
    assign m_entry_time  = etime_reg;
    assign m_total_time  = total_out_reg;
    assign m_entry_count = count_reg;

    always_comb begin
        sts.is_read     = cmd_reg;
        sts.rd_hit      = (32'(rs_reg) < 32'(used_reg)) && (32'(rs_reg) < SLOTS);
        sts.enabled     = enable_reg;
        sts.idx_at_end  = (idx_reg == used_reg);
        sts.table_full  = (used_reg == CNT_W'(SLOTS));
        sts.match       = (ram_rdata.task_id == prev_task_reg);
        sts.over_thr    = (total_reg > TIME_W'(thr_reg));
        sts.walk_at_end = (walk_reg == used_reg);
        sts.idx_zero    = (idx_reg == '0);
        sts.cur_greater = (cur_reg.time_us > ram_rdata.time_us);
        sts.out_free    = !m_valid_reg || m_ready;
    end

endmodule

FILE: verif/tb_task_runtime_profiler.sv
`timescale 1ns / 100ps
// self-checking testbench for the task run-time profiler with queued items and random idling
module tb_task_runtime_profiler;
    import trp_pkg::*;

    localparam int SLOT_COUNT  = SLOTS_DEFAULT;
    localparam int IDLE_LIMIT  = 4000;
    localparam int TAIL_CYCLES = 200;
    localparam int SETTLE      = 10;
    localparam int POOL_SIZE   = 20;
    localparam int PRINT_CAP   = 100;

    typedef struct packed {
        logic               command;
        logic [STAMP_W-1:0] timestamp_us;
        logic [TASK_W-1:0]  incoming_task;
        logic [RSLOT_W-1:0] read_slot;
        logic               hold_for_drain;
    } prof_item_t;

    typedef struct packed {
        status_t            status;
        logic [RSLOT_W-1:0] slot;
        logic [TASK_W-1:0]  entry_task;
        logic [TIME_W-1:0]  entry_time;
        logic [TIME_W-1:0]  total_time;
        logic [COUNT_W-1:0] entry_count;
    } prof_result_t;

    logic                  aclk            = 1'b0;
    logic                  aresetn         = 1'b0;
    logic                  cfg_wr_en       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index       = CFG_ENABLE;
    logic [CFG_DATA_W-1:0] cfg_wdata       = '0;
    logic                  s_valid         = 1'b0;
    logic                  s_ready;
    logic                  s_command       = 1'b0;
    logic [STAMP_W-1:0]    s_timestamp_us  = '0;
    logic [TASK_W-1:0]     s_incoming_task = '0;
    logic [RSLOT_W-1:0]    s_read_slot     = '0;
    logic                  m_valid;
    logic                  m_ready         = 1'b0;
    logic [STATUS_W-1:0]   m_status;
    logic [RSLOT_W-1:0]    m_slot;
    logic [TASK_W-1:0]     m_entry_task;
    logic [TIME_W-1:0]     m_entry_time;
    logic [TIME_W-1:0]     m_total_time;
    logic [COUNT_W-1:0]    m_entry_count;

    task_runtime_profiler u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_timestamp_us  (s_timestamp_us),
        .s_incoming_task (s_incoming_task),
        .s_read_slot     (s_read_slot),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_slot          (m_slot),
        .m_entry_task    (m_entry_task),
        .m_entry_time    (m_entry_time),
        .m_total_time    (m_total_time),
        .m_entry_count   (m_entry_count)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // profile table as the block should hold it
    logic [TASK_W-1:0]  prof_task [SLOT_COUNT];
    logic [TIME_W-1:0]  prof_time [SLOT_COUNT];
    int                 prof_used       = 0;
    logic [TIME_W-1:0]  prof_total      = '0;
    logic [TASK_W-1:0]  prof_prev_task  = '0;
    logic [STAMP_W-1:0] prof_prev_stamp = '0;
    logic               prof_enable     = 1'b1;
    logic [STAMP_W-1:0] prof_threshold  = THR_RESET;

    prof_item_t   pending_events[$];
    prof_result_t expected_reports[$];
    int           mismatch_count = 0;

    logic [STAMP_W-1:0] stamp_cursor = '0;
    logic [TASK_W-1:0]  task_pool [POOL_SIZE];

    function automatic logic [TIME_W-1:0] add_sat(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

    function automatic prof_result_t profile_event(prof_item_t it);
        prof_result_t       r;
        logic [STAMP_W-1:0] span;
        int                 hit;
        logic [TASK_W-1:0]  held_task;
        logic [TIME_W-1:0]  held_time;
        r = '0;
        if (it.command) begin
            r.slot = it.read_slot;
            if (it.read_slot < prof_used) begin
                r.status     = ST_READ_VALID;
                r.entry_task = prof_task[it.read_slot];
                r.entry_time = prof_time[it.read_slot];
            end else begin
                r.status = ST_READ_EMPTY;
            end
        end else if (!prof_enable) begin
            r.status = ST_DISABLED;
        end else begin
            span = it.timestamp_us - prof_prev_stamp;
            hit  = -1;
            for (int k = 0; k < prof_used; k++) begin
                if (hit < 0 && prof_task[k] == prof_prev_task) hit = k;
            end
            if (hit < 0 && prof_used < SLOT_COUNT) begin
                hit            = prof_used;
                prof_used      = prof_used + 1;
                prof_task[hit] = prof_prev_task;
                prof_time[hit] = '0;
            end
            if (hit >= 0) begin
                prof_time[hit] = add_sat(prof_time[hit], TIME_W'(span));
                prof_total     = add_sat(prof_total, TIME_W'(span));
            end
            if (prof_total > prof_threshold) begin
                prof_total = prof_total >> 1;
                for (int k = 0; k < SLOT_COUNT; k++) prof_time[k] = prof_time[k] >> 1;
            end
            if (hit > 0 && prof_time[hit] > prof_time[hit-1]) begin
                held_task        = prof_task[hit];
                held_time        = prof_time[hit];
                prof_task[hit]   = prof_task[hit-1];
                prof_time[hit]   = prof_time[hit-1];
                prof_task[hit-1] = held_task;
                prof_time[hit-1] = held_time;
                hit              = hit - 1;
            end
            prof_prev_task  = it.incoming_task;
            prof_prev_stamp = it.timestamp_us;
            if (hit >= 0) begin
                r.status     = ST_CHARGED;
                r.slot       = RSLOT_W'(hit);
                r.entry_task = prof_task[hit];
                r.entry_time = prof_time[hit];
            end else begin
                r.status = ST_FULL;
            end
        end
        r.total_time  = prof_total;
        r.entry_count = COUNT_W'(prof_used);
        return r;
    endfunction

    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        if (pick < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want_val);
        if (mismatch_count < PRINT_CAP)
            $display("%0t ns: %s mismatch, got 'h%0h, expected 'h%0h",
                     $realtime, what, got, want_val);
        mismatch_count++;
    endtask

    task automatic push_item(logic cmd, logic [STAMP_W-1:0] stamp, logic [TASK_W-1:0] tid,
                             logic [RSLOT_W-1:0] rs, logic hold);
        prof_item_t it;
        it.command        = cmd;
        it.timestamp_us   = stamp;
        it.incoming_task  = tid;
        it.read_slot      = rs;
        it.hold_for_drain = hold;
        if (!cmd) stamp_cursor = stamp;
        pending_events.push_back(it);
    endtask

    task automatic push_random(logic wide_ids);
        int                 pick;
        logic [STAMP_W-1:0] step;
        logic [TASK_W-1:0]  tid;
        logic [RSLOT_W-1:0] rs;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            rs = ($urandom_range(0, 2) != 0) ? RSLOT_W'($urandom_range(0, 15))
                                             : RSLOT_W'($urandom_range(0, 31));
            push_item(1'b1, $urandom, TASK_W'($urandom), rs, $urandom_range(0, 99) == 0);
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 80) step = $urandom_range(0, 400);
            else if (pick < 90) step = $urandom_range(0, 20000);
            else if (pick < 95) step = $urandom;
            else step = '0;
            if (wide_ids && $urandom_range(0, 1) == 1) tid = TASK_W'($urandom);
            else tid = task_pool[$urandom_range(0, POOL_SIZE-1)];
            push_item(1'b0, stamp_cursor + step, tid, RSLOT_W'($urandom),
                      $urandom_range(0, 99) == 0);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_ENABLE) prof_enable = data[0];
        else prof_threshold = data;
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_events.size() != 0 || s_valid || expected_reports.size() != 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // driver
    prof_item_t item_on_bus;
    int         send_gap  = 0;
    int         send_calm = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) expected_reports.push_back(profile_event(item_on_bus));
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    s_valid  <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_events.size() != 0 &&
                             (!pending_events[0].hold_for_drain || expected_reports.size() == 0)) begin
                    item_on_bus = pending_events.pop_front();
                    s_valid         <= 1'b1;
                    s_command       <= item_on_bus.command;
                    s_timestamp_us  <= item_on_bus.timestamp_us;
                    s_incoming_task <= item_on_bus.incoming_task;
                    s_read_slot     <= item_on_bus.read_slot;
                    if (send_calm != 0) begin
                        send_calm <= send_calm - 1;
                        send_gap  <= 0;
                    end else begin
                        send_gap <= gap_len();
                        if ($urandom_range(0, 49) == 0) send_calm <= $urandom_range(20, 60);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    prof_result_t want;
    int           recv_stall = 0;
    int           recv_calm  = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            recv_stall <= 0;
            recv_calm  <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    flag_mismatch("unexpected result", 64'(m_status), 64'(0));
                end else begin
                    want = expected_reports.pop_front();
                    if (m_status !== want.status)
                        flag_mismatch("status", 64'(m_status), 64'(want.status));
                    if (m_slot !== want.slot)
                        flag_mismatch("slot", 64'(m_slot), 64'(want.slot));
                    if (m_entry_task !== want.entry_task)
                        flag_mismatch("entry_task", 64'(m_entry_task), 64'(want.entry_task));
                    if (m_entry_time !== want.entry_time)
                        flag_mismatch("entry_time", 64'(m_entry_time), 64'(want.entry_time));
                    if (m_total_time !== want.total_time)
                        flag_mismatch("total_time", 64'(m_total_time), 64'(want.total_time));
                    if (m_entry_count !== want.entry_count)
                        flag_mismatch("entry_count", 64'(m_entry_count),
                                      64'(want.entry_count));
                end
            end
            if (recv_stall != 0) begin
                m_ready    <= 1'b0;
                recv_stall <= recv_stall - 1;
            end else if (recv_calm == 0 && $urandom_range(0, 3) == 0) begin
                m_ready    <= 1'b0;
                recv_stall <= gap_len();
            end else begin
                m_ready <= 1'b1;
            end
            if (recv_calm != 0) recv_calm <= recv_calm - 1;
            else if ($urandom_range(0, 199) == 0) recv_calm <= $urandom_range(50, 200);
        end
    end

    // watchdog
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge aclk);
        $display("task_runtime_profiler test failed");
        $finish;
    end

    initial begin
        for (int k = 0; k < SLOT_COUNT; k++) begin
            prof_task[k] = '0;
            prof_time[k] = '0;
        end
        task_pool[0] = '0;
        task_pool[1] = '1;
        for (int k = 2; k < POOL_SIZE; k++) task_pool[k] = TASK_W'($urandom);
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed items under reset settings
        push_item(1'b1, 32'hFFFF_FFFF, 16'hFFFF, 5'd0, 1'b0);
        push_item(1'b0, 32'd100, 16'hFFFF, 5'd31, 1'b0);
        push_item(1'b0, 32'd100, 16'h0000, 5'd0, 1'b0);
        push_item(1'b0, 32'd400, 16'h0007, 5'd0, 1'b0);
        push_item(1'b0, 32'd1400, 16'h0000, 5'd0, 1'b0);
        push_item(1'b1, 32'd0, 16'd0, 5'd0, 1'b1);
        push_item(1'b1, 32'd0, 16'd0, 5'd1, 1'b0);
        push_item(1'b1, 32'd0, 16'd0, 5'd2, 1'b0);
        push_item(1'b1, 32'd0, 16'd0, 5'd31, 1'b0);
        push_item(1'b0, 32'd6000, 16'h0001, 5'd0, 1'b0);
        push_item(1'b0, 32'd10, 16'h0002, 5'd0, 1'b0);
        push_item(1'b0, 32'hFFFF_FFFF, 16'h8000, 5'd0, 1'b1);
        push_item(1'b0, 32'd0, 16'h5555, 5'd0, 1'b0);
        push_item(1'b0, 32'd0, 16'hAAAA, 5'd0, 1'b0);
        push_item(1'b0, 32'h8000_0000, 16'h5555, 5'd0, 1'b0);
        push_item(1'b0, 32'h8000_0001, 16'hAAAA, 5'd0, 1'b0);
        for (int k = 0; k < 6; k++) push_item(1'b1, $urandom, TASK_W'($urandom), 5'(k), 1'b0);
        wait_idle();

        // disabled: switches ignored, reads still answered
        write_reg(CFG_ENABLE, 32'd0);
        for (int k = 0; k < 12; k++) push_random(1'b0);
        push_item(1'b0, 32'hFFFF_FFFF, 16'hFFFF, 5'd31, 1'b0);
        push_item(1'b1, 32'd0, 16'd0, 5'd0, 1'b0);
        wait_idle();
        write_reg(CFG_ENABLE, 32'd1);

        // halving on every switch that leaves a nonzero total
        write_reg(CFG_DECAY, 32'd0);
        for (int k = 0; k < 150; k++) push_random(1'b0);
        wait_idle();

        // no decay in practice
        write_reg(CFG_DECAY, 32'hFFFF_FFFF);
        for (int k = 0; k < 150; k++) push_random(1'b0);
        wait_idle();

        write_reg(CFG_DECAY, $urandom_range(1000, 100000));
        for (int k = 0; k < 300; k++) push_random(1'b0);
        wait_idle();

        write_reg(CFG_ENABLE, 32'd0);
        for (int k = 0; k < 60; k++) push_random(1'b0);
        wait_idle();
        write_reg(CFG_ENABLE, 32'd1);

        // many task ids until the table fills
        write_reg(CFG_DECAY, THR_RESET);
        for (int k = 0; k < 650; k++) push_random(1'b1);
        wait_idle();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_reports.size() != 0)
            flag_mismatch("leftover expectations", 64'(expected_reports.size()), 64'(0));
        if (mismatch_count == 0) $display("task_runtime_profiler test passed");
        else $display("task_runtime_profiler test failed");
        $finish;
    end

endmodule
